### sv/fcts_pkg.sv
package fcts_pkg;

    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int NUM_CLASSES_DEF  = 4;
    localparam int TASK_ID_BITS_DEF = 16;

    localparam int OP_W     = 3;
    localparam int CLASS_W  = 2;
    localparam int ID_W     = 16;
    localparam int GEN_W    = 32;
    localparam int TIME_W   = 48;
    localparam int SEQ_W    = 64;
    localparam int STATUS_W = 3;
    localparam int REASON_W = 3;
    localparam int PEND_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [OP_W-1:0] OP_SCHEDULE = 3'd0;
    localparam logic [OP_W-1:0] OP_RUN      = 3'd1;
    localparam logic [OP_W-1:0] OP_FRAME    = 3'd2;
    localparam logic [OP_W-1:0] OP_SET_GEN  = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_STALE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RAN      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_HELD     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd6;

    localparam logic [REASON_W-1:0] RS_NONE   = 3'd0;
    localparam logic [REASON_W-1:0] RS_FIFO   = 3'd1;
    localparam logic [REASON_W-1:0] RS_RENDER = 3'd2;
    localparam logic [REASON_W-1:0] RS_INPUT  = 3'd3;
    localparam logic [REASON_W-1:0] RS_AGING  = 3'd4;
    localparam logic [REASON_W-1:0] RS_FAIR   = 3'd5;
    localparam logic [REASON_W-1:0] RS_NORMAL = 3'd6;
    localparam logic [REASON_W-1:0] RS_BACKGR = 3'd7;

    localparam logic [CLASS_W-1:0] CL_RENDER = 2'd0;
    localparam logic [CLASS_W-1:0] CL_INPUT  = 2'd1;
    localparam logic [CLASS_W-1:0] CL_NORMAL = 2'd2;
    localparam logic [CLASS_W-1:0] CL_TIMER  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FIFO_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STARVATION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST      = 2'd3;

endpackage

### sv/fcts_ram.sv
module fcts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### sv/four_class_task_scheduler_with_aging_core.sv
// Channel | Direction | Handshake          | Payload
// request | in        | i_valid / o_stall  | operation, class, id, generation, time, frame
// result  | out       | o_valid / i_stall  | status, picked task and class, reason, counts
// config  | in        | i_cfg_valid/o_cfg_ready | register index and data
// Schedule, frame, clear and unused codes go from the execute state straight to the
// output state; run-one reads the timer head in priority mode and one head per class
// in fifo mode. A generation purge walks every class through the single read port
// of the entry memory.
// Reset is synchronous and active low; it clears all queue pointers and counters.
// A waiting result holds in the output register while i_stall is high; the block
// accepts no new request while a result waits there or an operation is in progress.
module four_class_task_scheduler_with_aging_core #(
    parameter int QUEUE_DEPTH  = fcts_pkg::QUEUE_DEPTH_DEF,
    parameter int NUM_CLASSES  = fcts_pkg::NUM_CLASSES_DEF,
    parameter int TASK_ID_BITS = fcts_pkg::TASK_ID_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [fcts_pkg::OP_W-1:0]         i_operation,
    input  logic [fcts_pkg::CLASS_W-1:0]      i_task_class,
    input  logic [fcts_pkg::ID_W-1:0]         i_task_id,
    input  logic [fcts_pkg::GEN_W-1:0]        i_task_generation,
    input  logic [fcts_pkg::TIME_W-1:0]       i_time_now,
    input  logic                              i_frame_armed_in,
    input  logic [fcts_pkg::TIME_W-1:0]       i_frame_deadline_in,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [fcts_pkg::STATUS_W-1:0]     o_status,
    output logic [fcts_pkg::ID_W-1:0]         o_picked_task_id,
    output logic [fcts_pkg::CLASS_W-1:0]      o_picked_class,
    output logic [fcts_pkg::REASON_W-1:0]     o_pick_reason,
    output logic [fcts_pkg::PEND_W-1:0]       o_pending_count,
    output logic [fcts_pkg::GEN_W-1:0]        o_current_generation,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fcts_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fcts_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import fcts_pkg::*;

    localparam int QW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(NUM_CLASSES);
    localparam int SLOTS = NUM_CLASSES * QUEUE_DEPTH;
    localparam int AW    = $clog2(SLOTS);
    localparam int CNTW  = $clog2(QUEUE_DEPTH + 1);
    localparam int EW    = TASK_ID_BITS + GEN_W + SEQ_W + TIME_W;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_RD_WAIT, S_RUN_CMP, S_RUN_POP,
        S_PG_RD, S_PG_WAIT, S_PG_WR, S_PG_NEXT, S_OUT
    } t_state;

    typedef struct packed {
        logic [TASK_ID_BITS-1:0] task_id;
        logic [GEN_W-1:0]        gen;
        logic [SEQ_W-1:0]        seq;
        logic [TIME_W-1:0]       tm;
    } t_entry;

    t_state r_state;

    // Configuration registers.
    logic              r_fifo_mode;
    logic [31:0]       r_starv;
    logic [31:0]       r_guard;
    logic [7:0]        r_max_burst;

    // Queue control and global state.
    logic [QW-1:0]     r_head  [NUM_CLASSES];
    logic [CNTW-1:0]   r_count [NUM_CLASSES];
    logic [SEQ_W-1:0]  r_seq;
    logic [GEN_W-1:0]  r_gen;
    logic [PEND_W-1:0] r_pending;
    logic [7:0]        r_burst;
    logic              r_armed;
    logic [TIME_W-1:0] r_deadline;

    // Latched request.
    logic [OP_W-1:0]         r_op;
    logic [CLASS_W-1:0]      r_cls;
    logic [TASK_ID_BITS-1:0] r_id;
    logic [GEN_W-1:0]        r_rgen;
    logic [TIME_W-1:0]       r_now;

    // Run-one working registers.
    logic [CW-1:0]     r_rd_cls;
    logic              r_found;
    logic [SEQ_W-1:0]  r_best;
    logic [CW-1:0]     r_sel;
    logic              r_guarded;
    logic              r_aged;

    // Purge walk registers.
    logic [CW-1:0]     r_pg_cls;
    logic [CNTW-1:0]   r_pg_k;
    logic [CNTW-1:0]   r_pg_kept;
    logic [QW-1:0]     r_pg_pos;

    // Result register.
    logic                r_ovalid;
    logic [STATUS_W-1:0] r_status;
    logic [ID_W-1:0]     r_pid;
    logic [CLASS_W-1:0]  r_pcls;
    logic [REASON_W-1:0] r_reason;

    // Memory port.
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_entry        mem_rdata;
    logic [EW-1:0] mem_rbits;

    fcts_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_entries (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rbits)
    );
    assign mem_rdata = t_entry'(mem_rbits);

    function automatic logic [AW-1:0] slot_of(input logic [CW-1:0] c, input logic [QW-1:0] p);
        logic [AW:0] s;
        s = (AW+1)'(c) * (AW+1)'(QUEUE_DEPTH) + (AW+1)'(p);
        return s[AW-1:0];
    endfunction

    function automatic logic [QW-1:0] wrap_add(input logic [QW-1:0] a, input logic [CNTW-1:0] b);
        logic [CNTW:0] s;
        s = (CNTW+1)'(a) + (CNTW+1)'(b);
        if (s >= (CNTW+1)'(QUEUE_DEPTH)) begin
            s = s - (CNTW+1)'(QUEUE_DEPTH);
        end
        return s[QW-1:0];
    endfunction

    logic [CW-1:0] req_cls;
    assign req_cls = CW'(r_cls);

    // Signed 48-bit differences for the guard and aging tests.
    logic [TIME_W-1:0] guard_diff, age_diff;
    logic              guard_hit, age_hit;
    assign guard_diff = r_deadline - r_now;
    assign age_diff   = r_now - mem_rdata.tm;
    assign guard_hit  = guard_diff[TIME_W-1] ||
                        (guard_diff <= {{(TIME_W-32){1'b0}}, r_guard});
    assign age_hit    = !age_diff[TIME_W-1] &&
                        (age_diff >= {{(TIME_W-32){1'b0}}, r_starv});

    logic busy_in;
    assign busy_in  = (r_state != S_IDLE) || r_ovalid;
    assign o_stall  = busy_in;
    assign o_cfg_ready = (r_state == S_IDLE);

    assign o_valid              = r_ovalid;
    assign o_status             = r_status;
    assign o_picked_task_id     = r_pid;
    assign o_picked_class       = r_pcls;
    assign o_pick_reason        = r_reason;
    assign o_pending_count      = r_pending;
    assign o_current_generation = r_gen;

    // Memory address and write data.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = slot_of(req_cls, wrap_add(r_head[req_cls], r_count[req_cls]));
        mem_wdata = '{task_id: r_id, gen: r_rgen, seq: r_seq, tm: r_now};
        mem_raddr = slot_of(r_rd_cls, r_head[r_rd_cls]);
        unique case (r_state)
            S_EXEC: begin
                if (r_op == OP_SCHEDULE && !(r_rgen != '0 && r_rgen != r_gen) &&
                    r_count[req_cls] < CNTW'(QUEUE_DEPTH)) begin
                    mem_we = 1'b1;
                end
            end
            S_PG_RD, S_PG_WAIT: begin
                mem_raddr = slot_of(r_pg_cls, r_pg_pos);
            end
            S_PG_WR: begin
                mem_waddr = slot_of(r_pg_cls, wrap_add(r_head[r_pg_cls], r_pg_kept));
                mem_wdata = mem_rdata;
                mem_we    = (mem_rdata.gen == '0 || mem_rdata.gen == r_gen);
            end
            default: begin
            end
        endcase
    end

    // Main sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fifo_mode <= 1'b0;
            r_starv     <= '0;
            r_guard     <= '0;
            r_max_burst <= 8'd1;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_head[c]  <= '0;
                r_count[c] <= '0;
            end
            r_seq      <= '0;
            r_gen      <= '0;
            r_pending  <= '0;
            r_burst    <= '0;
            r_armed    <= 1'b0;
            r_deadline <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_FIFO_MODE:  r_fifo_mode <= i_cfg_data[0];
                    CFG_STARVATION: r_starv     <= i_cfg_data;
                    CFG_GUARD:      r_guard     <= i_cfg_data;
                    CFG_BURST:      r_max_burst <= i_cfg_data[7:0];
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && !busy_in) begin
                        r_op     <= i_operation;
                        r_cls    <= i_task_class;
                        r_id     <= TASK_ID_BITS'(i_task_id);
                        r_rgen   <= i_task_generation;
                        r_now    <= i_time_now;
                        r_status <= ST_DONE;
                        r_pid    <= '0;
                        r_pcls   <= '0;
                        r_reason <= RS_NONE;
                        r_rd_cls <= '0;
                        r_found  <= 1'b0;
                        if (i_operation == OP_FRAME) begin
                            r_armed    <= i_frame_armed_in;
                            r_deadline <= i_frame_deadline_in;
                        end
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_OUT;
                    priority case (r_op)
                        OP_SCHEDULE: begin
                            if (r_rgen != '0 && r_rgen != r_gen) begin
                                r_status <= ST_STALE;
                            end else if (r_count[req_cls] >= CNTW'(QUEUE_DEPTH)) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_seq            <= r_seq + 1'b1;
                                r_count[req_cls] <= r_count[req_cls] + 1'b1;
                                r_pending        <= r_pending + 1'b1;
                                r_status         <= ST_ACCEPTED;
                            end
                        end
                        OP_RUN: begin
                            r_guarded <= r_armed && guard_hit;
                            r_rd_cls  <= r_fifo_mode ? CW'(0) : CW'(CL_TIMER);
                            r_state   <= S_RD_WAIT;
                        end
                        OP_SET_GEN: begin
                            r_gen     <= r_rgen;
                            r_pg_cls  <= '0;
                            r_pg_k    <= '0;
                            r_pg_kept <= '0;
                            r_pg_pos  <= r_head[0];
                            r_state   <= S_PG_RD;
                        end
                        OP_CLEAR: begin
                            for (int c = 0; c < NUM_CLASSES; c++) begin
                                r_head[c]  <= '0;
                                r_count[c] <= '0;
                            end
                            r_pending <= '0;
                            r_burst   <= '0;
                        end
                        default: begin
                        end
                    endcase
                end
                S_RD_WAIT: begin
                    r_state <= S_RUN_CMP;
                end
                S_RUN_CMP: begin
                    if (r_fifo_mode) begin
                        // Compare one head per pass, oldest sequence wins.
                        if (r_count[r_rd_cls] != '0 &&
                            (!r_found || mem_rdata.seq < r_best)) begin
                            r_found <= 1'b1;
                            r_best  <= mem_rdata.seq;
                            r_sel   <= r_rd_cls;
                        end
                        if (r_rd_cls == CW'(NUM_CLASSES - 1)) begin
                            r_state <= S_RUN_POP;
                        end else begin
                            r_rd_cls <= r_rd_cls + 1'b1;
                            r_state  <= S_RD_WAIT;
                        end
                    end else begin
                        r_aged  <= age_hit;
                        r_state <= S_RUN_POP;
                    end
                end
                S_RUN_POP: begin
                    logic          fnd;
                    logic [CW-1:0] sel;
                    logic [REASON_W-1:0] rsn;
                    logic          tmr;
                    fnd = 1'b1;
                    sel = '0;
                    rsn = RS_FIFO;
                    tmr = (r_count[CL_TIMER] != '0) && !r_guarded;
                    if (r_fifo_mode) begin
                        fnd = r_found;
                        sel = r_sel;
                    end else if (r_count[CL_RENDER] != '0) begin
                        sel = CW'(CL_RENDER); rsn = RS_RENDER;
                    end else if (r_count[CL_INPUT] != '0) begin
                        sel = CW'(CL_INPUT); rsn = RS_INPUT;
                    end else if (tmr && r_aged) begin
                        sel = CW'(CL_TIMER); rsn = RS_AGING;
                    end else if (tmr && r_burst >= r_max_burst) begin
                        sel = CW'(CL_TIMER); rsn = RS_FAIR;
                    end else if (r_count[CL_NORMAL] != '0) begin
                        sel = CW'(CL_NORMAL); rsn = RS_NORMAL;
                    end else if (tmr) begin
                        sel = CW'(CL_TIMER); rsn = RS_BACKGR;
                    end else begin
                        fnd = 1'b0;
                    end
                    if (fnd) begin
                        r_rd_cls <= sel;
                        r_sel    <= sel;
                        r_reason <= rsn;
                        r_pcls   <= CLASS_W'(sel);
                        r_state  <= S_PG_NEXT;
                        r_found  <= 1'b1;
                    end else begin
                        r_reason <= RS_NONE;
                        r_status <= (r_pending != '0) ? ST_HELD : ST_EMPTY;
                        r_state  <= S_OUT;
                    end
                end
                S_PG_NEXT: begin
                    if (r_op == OP_RUN) begin
                        // Wait for the selected head read, then pop it.
                        if (r_found) begin
                            r_found <= 1'b0;
                        end else begin
                            r_pid        <= ID_W'(mem_rdata.task_id);
                            r_status     <= ST_RAN;
                            r_head[r_sel]  <= wrap_add(r_head[r_sel], CNTW'(1));
                            r_count[r_sel] <= r_count[r_sel] - 1'b1;
                            r_pending    <= r_pending - 1'b1;
                            if (r_sel == CW'(CL_TIMER)) begin
                                r_burst <= '0;
                            end else if (r_burst != 8'hFF) begin
                                r_burst <= r_burst + 1'b1;
                            end
                            r_state <= S_OUT;
                        end
                    end else begin
                        // Finish one class of the purge and move to the next.
                        r_count[r_pg_cls] <= r_pg_kept;
                        if (r_pg_cls == CW'(NUM_CLASSES - 1)) begin
                            r_state <= S_OUT;
                        end else begin
                            r_pg_cls  <= r_pg_cls + 1'b1;
                            r_pg_pos  <= r_head[r_pg_cls + 1'b1];
                            r_pg_k    <= '0;
                            r_pg_kept <= '0;
                            r_state   <= S_PG_RD;
                        end
                    end
                end
                S_PG_RD: begin
                    if (r_pg_k == r_count[r_pg_cls]) begin
                        r_state <= S_PG_NEXT;
                    end else begin
                        r_state <= S_PG_WAIT;
                    end
                end
                S_PG_WAIT: begin
                    r_state <= S_PG_WR;
                end
                S_PG_WR: begin
                    // Compact kept entries toward the head of the class, so a write
                    // never lands on an entry that is still to be read.
                    if (mem_we) begin
                        r_pg_kept <= r_pg_kept + 1'b1;
                    end else begin
                        r_pending <= r_pending - 1'b1;
                    end
                    r_pg_k   <= r_pg_k + 1'b1;
                    r_pg_pos <= wrap_add(r_pg_pos, CNTW'(1));
                    r_state  <= S_PG_RD;
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

### sv/fcts_checker.sv
module fcts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_status,
    input logic [15:0] o_picked_task_id,
    input logic [2:0]  o_pick_reason,
    input logic [6:0]  o_pending_count
);
    import fcts_pkg::*;

    // A result waits while stalled.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status))
        else $error("result dropped under stall");

    // A request accepted produces a result before the next one is taken.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request accepted while busy");

    // Only a pop carries a reason.
    a_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_RAN |-> o_pick_reason == RS_NONE &&
        o_picked_task_id == '0)
        else $error("reason without a pop");

    // Pending never exceeds capacity of four queues.
    a_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pending_count <= 7'd64)
        else $error("pending count overflow");
endmodule

bind four_class_task_scheduler_with_aging_core fcts_checker u_fcts_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_status        (o_status),
    .o_picked_task_id(o_picked_task_id),
    .o_pick_reason   (o_pick_reason),
    .o_pending_count (o_pending_count)
);

### tb/sv/tb_four_class_task_scheduler_with_aging_core.sv
module tb_four_class_task_scheduler_with_aging_core;
    import fcts_pkg::*;

    localparam int DEPTH      = 16;
    localparam int SLOTS      = 4 * DEPTH;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_LEN   = 300;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [CLASS_W-1:0] cls;
        logic [ID_W-1:0]    id;
        logic [GEN_W-1:0]   gen;
        logic [TIME_W-1:0]  now;
        logic               armed;
        logic [TIME_W-1:0]  deadline;
    } sched_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     id;
        logic [CLASS_W-1:0]  cls;
        logic [REASON_W-1:0] reason;
        logic [PEND_W-1:0]   pending;
        logic [GEN_W-1:0]    gen;
    } sched_res_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [OP_W-1:0] i_operation = '0;
    logic [CLASS_W-1:0] i_task_class = '0;
    logic [ID_W-1:0] i_task_id = '0;
    logic [GEN_W-1:0] i_task_generation = '0;
    logic [TIME_W-1:0] i_time_now = '0;
    logic i_frame_armed_in = 1'b0;
    logic [TIME_W-1:0] i_frame_deadline_in = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [ID_W-1:0] o_picked_task_id;
    logic [CLASS_W-1:0] o_picked_class;
    logic [REASON_W-1:0] o_pick_reason;
    logic [PEND_W-1:0] o_pending_count;
    logic [GEN_W-1:0] o_current_generation;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    four_class_task_scheduler_with_aging_core u_dut (.*);

    always #2 i_clk = ~i_clk;

    // Shadow scheduler state.
    logic [ID_W-1:0]   sh_task [SLOTS];
    logic [GEN_W-1:0]  sh_gen  [SLOTS];
    logic [SEQ_W-1:0]  sh_seq  [SLOTS];
    logic [TIME_W-1:0] sh_time [SLOTS];
    int                sh_head [4];
    int                sh_count[4];
    logic [SEQ_W-1:0]  sh_seq_ctr;
    logic [GEN_W-1:0]  sh_gen_reg;
    int                sh_pending;
    int                sh_burst;
    logic              sh_armed;
    logic [TIME_W-1:0] sh_deadline;
    logic              cfg_fifo;
    logic [31:0]       cfg_starve;
    logic [31:0]       cfg_guard;
    logic [7:0]        cfg_burst;

    sched_req_t request_queue[$];
    sched_res_t expected_results[$];
    sched_req_t offered;
    logic       offer_taken = 1'b0;
    int         errors = 0;
    int         requests_accepted = 0;
    int         idle_cycles = 0;
    int         cycle = 0;
    logic [TIME_W-1:0] tb_clock = 48'd1000;
    logic [GEN_W-1:0]  gen_plan = '0;

    // Wrapped 48-bit difference read as signed.
    function automatic longint signed tick_diff(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] d;
        d = a - b;
        return signed'({{16{d[TIME_W-1]}}, d});
    endfunction

    function automatic void shadow_reset();
        for (int c = 0; c < 4; c++) begin
            sh_head[c] = 0;
            sh_count[c] = 0;
        end
        sh_seq_ctr = '0;
        sh_gen_reg = '0;
        sh_pending = 0;
        sh_burst = 0;
        sh_armed = 1'b0;
        sh_deadline = '0;
        cfg_fifo = 1'b0;
        cfg_starve = '0;
        cfg_guard = '0;
        cfg_burst = 8'd1;
    endfunction

    function automatic logic [ID_W-1:0] pop_head(int c);
        logic [ID_W-1:0] id;
        id = sh_task[c * DEPTH + sh_head[c]];
        sh_head[c] = (sh_head[c] + 1) % DEPTH;
        sh_count[c]--;
        sh_pending--;
        if (c == CL_TIMER) sh_burst = 0;
        else if (sh_burst < 255) sh_burst++;
        return id;
    endfunction

    // Drop entries whose nonzero tag differs from the new generation and compact.
    function automatic void purge_stale();
        logic [ID_W-1:0]   t [DEPTH];
        logic [GEN_W-1:0]  g [DEPTH];
        logic [SEQ_W-1:0]  s [DEPTH];
        logic [TIME_W-1:0] tm[DEPTH];
        int kept;
        int pos;
        int slot;
        for (int c = 0; c < 4; c++) begin
            kept = 0;
            pos = sh_head[c];
            for (int k = 0; k < sh_count[c]; k++) begin
                slot = c * DEPTH + pos;
                if (sh_gen[slot] == 0 || sh_gen[slot] == sh_gen_reg) begin
                    t[kept] = sh_task[slot];
                    g[kept] = sh_gen[slot];
                    s[kept] = sh_seq[slot];
                    tm[kept] = sh_time[slot];
                    kept++;
                end else begin
                    sh_pending--;
                end
                pos = (pos + 1) % DEPTH;
            end
            for (int k = 0; k < kept; k++) begin
                sh_task[c * DEPTH + k] = t[k];
                sh_gen[c * DEPTH + k] = g[k];
                sh_seq[c * DEPTH + k] = s[k];
                sh_time[c * DEPTH + k] = tm[k];
            end
            sh_head[c] = 0;
            sh_count[c] = kept;
        end
    endfunction

    // Applies one request to the shadow state and returns the expected result.
    function automatic sched_res_t predict_outcome(sched_req_t r);
        sched_res_t res;
        int slot;
        int sel;
        logic found;
        logic guarded;
        logic timer_ok;
        logic [SEQ_W-1:0] best;
        res = '0;
        res.status = ST_DONE;
        case (r.op)
            OP_SCHEDULE: begin
                if (r.gen != 0 && r.gen != sh_gen_reg) begin
                    res.status = ST_STALE;
                end else if (sh_count[r.cls] >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    slot = r.cls * DEPTH + (sh_head[r.cls] + sh_count[r.cls]) % DEPTH;
                    sh_task[slot] = r.id;
                    sh_gen[slot] = r.gen;
                    sh_seq[slot] = sh_seq_ctr;
                    sh_time[slot] = r.now;
                    sh_seq_ctr++;
                    sh_count[r.cls]++;
                    sh_pending++;
                    res.status = ST_ACCEPTED;
                end
            end
            OP_RUN: begin
                found = 1'b0;
                sel = 0;
                if (cfg_fifo) begin
                    best = '0;
                    for (int c = 0; c < 4; c++) begin
                        if (sh_count[c] != 0 &&
                            (!found || sh_seq[c * DEPTH + sh_head[c]] < best)) begin
                            found = 1'b1;
                            best = sh_seq[c * DEPTH + sh_head[c]];
                            sel = c;
                        end
                    end
                    res.reason = RS_FIFO;
                end else begin
                    guarded = sh_armed &&
                        tick_diff(sh_deadline, r.now) <= longint'(cfg_guard);
                    timer_ok = sh_count[CL_TIMER] != 0 && !guarded;
                    found = 1'b1;
                    if (sh_count[CL_RENDER] != 0) begin
                        sel = CL_RENDER; res.reason = RS_RENDER;
                    end else if (sh_count[CL_INPUT] != 0) begin
                        sel = CL_INPUT; res.reason = RS_INPUT;
                    end else if (timer_ok && tick_diff(r.now,
                                 sh_time[CL_TIMER * DEPTH + sh_head[CL_TIMER]]) >=
                                 longint'(cfg_starve)) begin
                        sel = CL_TIMER; res.reason = RS_AGING;
                    end else if (timer_ok && sh_burst >= cfg_burst) begin
                        sel = CL_TIMER; res.reason = RS_FAIR;
                    end else if (sh_count[CL_NORMAL] != 0) begin
                        sel = CL_NORMAL; res.reason = RS_NORMAL;
                    end else if (timer_ok) begin
                        sel = CL_TIMER; res.reason = RS_BACKGR;
                    end else begin
                        found = 1'b0;
                    end
                end
                if (found) begin
                    res.id = pop_head(sel);
                    res.cls = CLASS_W'(sel);
                    res.status = ST_RAN;
                end else begin
                    res.reason = RS_NONE;
                    res.status = sh_pending != 0 ? ST_HELD : ST_EMPTY;
                end
            end
            OP_FRAME: begin
                sh_armed = r.armed;
                sh_deadline = r.deadline;
            end
            OP_SET_GEN: begin
                sh_gen_reg = r.gen;
                purge_stale();
            end
            OP_CLEAR: begin
                for (int c = 0; c < 4; c++) begin
                    sh_head[c] = 0;
                    sh_count[c] = 0;
                end
                sh_pending = 0;
                sh_burst = 0;
            end
            default: ;
        endcase
        res.pending = PEND_W'(sh_pending);
        res.gen = sh_gen_reg;
        return res;
    endfunction

    function automatic void add_request(logic [OP_W-1:0] op, logic [CLASS_W-1:0] cls,
                                        logic [ID_W-1:0] id, logic [GEN_W-1:0] gen,
                                        logic [TIME_W-1:0] now, logic armed,
                                        logic [TIME_W-1:0] deadline);
        request_queue.push_back('{op, cls, id, gen, now, armed, deadline});
    endfunction

    // Mostly plausible traffic around a slowly advancing clock, with some noise.
    function automatic void add_random_request();
        sched_req_t r;
        int p;
        int g;
        r = '0;
        p = $urandom_range(99);
        r.id = ID_W'($urandom);
        r.cls = CLASS_W'($urandom_range(3));
        r.armed = 1'($urandom_range(1));
        if ($urandom_range(99) < 2) tb_clock = TIME_W'({$urandom, $urandom});
        else tb_clock = tb_clock + TIME_W'($urandom_range(40));
        if (p < 48) begin
            r.op = OP_SCHEDULE;
            g = $urandom_range(99);
            r.gen = g < 65 ? '0 : (g < 90 ? gen_plan : $urandom);
            r.now = tb_clock - TIME_W'($urandom_range(300));
        end else if (p < 85) begin
            r.op = OP_RUN;
            r.now = tb_clock;
        end else if (p < 92) begin
            r.op = OP_FRAME;
            r.deadline = $urandom_range(9) == 0 ? TIME_W'({$urandom, $urandom})
                         : tb_clock + TIME_W'($urandom_range(200)) - TIME_W'(60);
            r.now = TIME_W'($urandom);
        end else if (p < 95) begin
            r.op = OP_SET_GEN;
            g = $urandom_range(3);
            r.gen = g == 0 ? gen_plan : (g == 1 ? $urandom : $urandom_range(3));
            gen_plan = r.gen;
        end else if (p < 97) begin
            r.op = OP_CLEAR;
        end else begin
            r.op = OP_W'($urandom_range(7, 5));
            r.gen = $urandom;
            r.now = TIME_W'({$urandom, $urandom});
        end
        request_queue.push_back(r);
    endfunction

    // Request driver.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || offer_taken) begin
            offer_taken = 1'b0;
            if (request_queue.size() > 0 &&
                ((cycle > 6000 && cycle < 9000) || $urandom_range(99) >= 19)) begin
                offered = request_queue.pop_front();
                i_operation <= offered.op;
                i_task_class <= offered.cls;
                i_task_id <= offered.id;
                i_task_generation <= offered.gen;
                i_time_now <= offered.now;
                i_frame_armed_in <= offered.armed;
                i_frame_deadline_in <= offered.deadline;
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result stall, with one long hold-off once traffic is under way.
    int  hold_left = 0;
    logic hold_done = 1'b0;
    always @(negedge i_clk) begin
        if (!hold_done && requests_accepted >= 400) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !(cycle > 6000 && cycle < 9000) && $urandom_range(99) < 19;
        end
    end

    // Acceptance, result checking and the watchdog.
    always @(posedge i_clk) begin
        sched_res_t exp_res;
        logic active;
        cycle++;
        active = 1'b0;
        if (i_rst_n && i_valid && !o_stall) begin
            expected_results.push_back(predict_outcome(offered));
            offer_taken = 1'b1;
            requests_accepted++;
            active = 1'b1;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            active = 1'b1;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result, status %0d", o_status);
            end else begin
                exp_res = expected_results.pop_front();
                if (o_status !== exp_res.status || o_picked_task_id !== exp_res.id ||
                    o_picked_class !== exp_res.cls || o_pick_reason !== exp_res.reason ||
                    o_pending_count !== exp_res.pending ||
                    o_current_generation !== exp_res.gen) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp st%0d id%h cl%0d rs%0d pend%0d gen%h, got st%0d id%h cl%0d rs%0d pend%0d gen%h",
                                 exp_res.status, exp_res.id, exp_res.cls, exp_res.reason,
                                 exp_res.pending, exp_res.gen, o_status, o_picked_task_id,
                                 o_picked_class, o_pick_reason, o_pending_count,
                                 o_current_generation);
                end
            end
        end
        if (i_cfg_valid && o_cfg_ready) active = 1'b1;
        idle_cycles = active ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_FIFO_MODE:  cfg_fifo = data[0];
            CFG_STARVATION: cfg_starve = data;
            CFG_GUARD:      cfg_guard = data;
            CFG_BURST:      cfg_burst = data[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (request_queue.size() != 0 || i_valid || expected_results.size() != 0);
        repeat (20) @(posedge i_clk);
    endtask

    // Settings per phase: fifo mode, starvation, guard window, burst limit.
    logic [31:0] phase_cfg [8][4] = '{
        '{0, 0, 0, 1}, '{1, 0, 0, 1}, '{0, 100, 50, 3}, '{0, 32'hFFFFFFFF, 32'hFFFFFFFF, 255},
        '{1, 32'hFFFFFFFF, 0, 255}, '{0, 20, 32'hFFFFFFFF, 0}, '{0, 400, 120, 2},
        '{0, 60, 10, 1}};

    initial begin
        shadow_reset();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty run, extremes, stale and full rejects, guard, purge, clear.
        add_request(OP_RUN, 0, 0, 0, 0, 0, 0);
        add_request(OP_SCHEDULE, CL_RENDER, 16'hFFFF, 0, 48'hFFFFFFFFFFFF, 0, 0);
        add_request(OP_SCHEDULE, CL_INPUT, 16'h0000, 32'hFFFFFFFF, 0, 0, 0);
        add_request(OP_SET_GEN, 0, 0, 32'hFFFFFFFF, 0, 0, 0);
        add_request(OP_SCHEDULE, CL_NORMAL, 16'h1234, 32'hFFFFFFFF, 5, 0, 0);
        for (int k = 0; k < 16; k++)
            add_request(OP_SCHEDULE, CL_TIMER, ID_W'(k), k[0] ? 32'hFFFFFFFF : 0,
                        TIME_W'(k), 0, 0);
        add_request(OP_SCHEDULE, CL_TIMER, 16'hBEEF, 0, 0, 0, 0);
        add_request(OP_SCHEDULE, CL_TIMER, 16'hBEEF, 32'd7, 0, 0, 0);
        add_request(OP_FRAME, 0, 0, 0, 0, 1'b1, 48'h800000000000);
        add_request(OP_RUN, 0, 0, 0, 0, 0, 0);
        add_request(OP_RUN, 0, 0, 0, 0, 0, 0);
        add_request(OP_RUN, 0, 0, 0, 0, 0, 0);
        add_request(3'd5, 3, 16'hFFFF, 32'hFFFFFFFF, 48'hFFFFFFFFFFFF, 1, 48'hFFFFFFFFFFFF);
        add_request(3'd7, 0, 0, 0, 0, 0, 0);
        add_request(OP_SET_GEN, 0, 0, 0, 0, 0, 0);
        add_request(OP_FRAME, 0, 0, 0, 0, 1'b0, 0);
        add_request(OP_RUN, 0, 0, 0, 48'h7FFFFFFFFFFF, 0, 0);
        add_request(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        add_request(OP_RUN, 0, 0, 0, 0, 0, 0);
        wait_drained();

        // Random phases under different register settings.
        for (int ph = 0; ph < 8; ph++) begin
            write_register(CFG_FIFO_MODE, phase_cfg[ph][0]);
            write_register(CFG_STARVATION, phase_cfg[ph][1]);
            write_register(CFG_GUARD, phase_cfg[ph][2]);
            write_register(CFG_BURST, phase_cfg[ph][3]);
            for (int k = 0; k < 210; k++) add_random_request();
            wait_drained();
        end

        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
